/* design/edist_pkg.sv */
// Shared types and constants for the euclidean distance engine.
// No dependencies; every other design file imports this package.
package edist_pkg;

   // Field widths
   localparam int FEAT_W = 8;
   localparam int IDX_W  = 13;
   localparam int SUM_W  = 24;
   localparam int SQ_W   = 2 * FEAT_W;
   localparam int DIST_W = SUM_W / 2;

   // Saturation limit: element count times the largest square, capped at 24 bits
   localparam int          MAX_ELEMENTS = 256;
   localparam longint      SQ_MAX       = 65025;
   localparam longint      ACC_MAX      = 64'hFF_FFFF;
   localparam longint      SUM_RAW      = longint'(MAX_ELEMENTS) * SQ_MAX;
   localparam logic [SUM_W-1:0] SUM_LIMIT =
      SUM_W'((SUM_RAW > ACC_MAX) ? ACC_MAX : SUM_RAW);

   // First trial bit of the digit-by-digit square root
   localparam logic [SUM_W-1:0] SQRT_BIT0 = SUM_W'(1) << (SUM_W - 2);

   // Depth of the queue between accumulator and square root
   localparam int QUEUE_DEPTH = 4;

   // One finished vector pair waiting for its root
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } entry_type;

endpackage

/* design/edist_front.sv */
// Front end: squares element differences and accumulates them per vector pair.
// Depends on edist_pkg; pushes finished sums into edist_queue.
module edist_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [edist_pkg::FEAT_W-1:0] req_feature_a,
   input  logic [edist_pkg::FEAT_W-1:0] req_feature_b,
   input  logic [edist_pkg::IDX_W-1:0]  req_row_index,
   input  logic [edist_pkg::IDX_W-1:0]  req_col_index,
   input  logic                      req_last_element,
   output logic                      push_valid,
   output edist_pkg::entry_type      push_entry,
   input  logic                      queue_full
);
   import edist_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   logic [SQ_W-1:0]   s1_sq_ff;
   logic [IDX_W-1:0]  s1_row_ff;
   logic [IDX_W-1:0]  s1_col_ff;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [FEAT_W-1:0] diff;
   logic [SUM_W:0]    sum_raw;
   logic [SUM_W-1:0]  sum_sat;
   logic              stall;
   logic              advance;

   // Hold the square stage while a finished sum cannot enter the queue
   assign stall     = s1_valid_ff & s1_last_ff & queue_full;
   assign req_ready = ~stall;
   assign advance   = s1_valid_ff & ~stall;

   // Absolute difference of the two elements
   assign diff = (req_feature_a >= req_feature_b) ? (req_feature_a - req_feature_b)
                                                   : (req_feature_b - req_feature_a);

   // Add the square into the running sum, saturating at the limit
   assign sum_raw = {1'b0, acc_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, s1_sq_ff};
   assign sum_sat = (sum_raw > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_raw[SUM_W-1:0];

   assign push_valid     = advance & s1_last_ff;
   assign push_entry.sum = sum_sat;
   assign push_entry.row = s1_row_ff;
   assign push_entry.col = s1_col_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
   end

   // Clear on the last element, keep the running sum otherwise
   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         acc_in = s1_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
      end
   end

   // Square stage payload
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_sq_ff   <= SQ_W'(diff) * SQ_W'(diff);
         s1_last_ff <= req_last_element;
         s1_row_ff  <= req_row_index;
         s1_col_ff  <= req_col_index;
      end
   end

   a_acc_limit : assert property (@(posedge clock) disable iff (reset)
      acc_ff <= SUM_LIMIT)
      else $error("accumulator above saturation limit");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("push into a full queue");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      push_valid |=> acc_ff == '0)
      else $error("accumulator not cleared after last element");

endmodule

/* design/edist_queue.sv */
// Small first-in first-out queue of finished sums between front and back end.
// Depends on edist_pkg for the entry type.
module edist_queue #(
   parameter int DEPTH = edist_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  edist_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop_ready,
   output logic                 pop_valid,
   output edist_pkg::entry_type pop_entry
);
   import edist_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop_ready & pop_valid;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_count_grow : assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not follow a push");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

/* design/edist_sqrt.sv */
// Back end: floor square root, one digit per cycle, and the result register.
// Depends on edist_pkg; pops finished sums from edist_queue.
module edist_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   input  edist_pkg::entry_type        pop_entry,
   output logic                        pop_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [edist_pkg::DIST_W-1:0] rsp_distance,
   output logic [edist_pkg::SUM_W-1:0]  rsp_sum_squares,
   output logic [edist_pkg::IDX_W-1:0]  rsp_pair_row,
   output logic [edist_pkg::IDX_W-1:0]  rsp_pair_col
);
   import edist_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   entry_type         job_ff;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]  bit_ff;
   logic [SUM_W:0]    trial;
   logic              take;
   logic              out_free;
   logic              out_load;
   logic [SUM_W-1:0]  out_root;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] dist_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  col_ff;

   assign pop_ready = (state_ff == ST_IDLE);
   assign take      = pop_ready & pop_valid;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // One digit of the root: try root + bit against the remainder
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};
   always_comb begin
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = rem_ff - trial[SUM_W-1:0];
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
   end

   // Fetch, iterate to the unit bit, then load the result register once it is free
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      out_root = root_in;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (bit_ff[0]) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            out_root = root_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Iteration registers
   always_ff @(posedge clock) begin
      if (take) begin
         job_ff  <= pop_entry;
         rem_ff  <= pop_entry.sum;
         root_ff <= '0;
         bit_ff  <= SQRT_BIT0;
      end else if (state_ff == ST_CALC) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         dist_ff <= out_root[DIST_W-1:0];
         sum_ff  <= job_ff.sum;
         row_ff  <= job_ff.row;
         col_ff  <= job_ff.col;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_sum_squares = sum_ff;
   assign rsp_pair_row    = row_ff;
   assign rsp_pair_col    = col_ff;

   a_root_low : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({{DIST_W{1'b0}}, dist_ff} * {{DIST_W{1'b0}}, dist_ff}) <= sum_ff)
      else $error("root too large");

   a_root_high : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (({{(DIST_W + 1){1'b0}}, dist_ff} + (SUM_W + 1)'(1)) *
          ({{(DIST_W + 1){1'b0}}, dist_ff} + (SUM_W + 1)'(1))) > {1'b0, sum_ff})
      else $error("root too small");

   a_hold_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result held back with an empty output register");

endmodule

/* design/euclidean_distance_engine.sv */
// Euclidean distance engine: sum of squared differences and its floor root.
// A finished sum passes the square stage and the queue, then the square root
// unit fetches it, runs its 12 one-digit steps and loads the result register.
// One element per cycle unless stalled; the root unit takes a new sum only when
// idle, so short pairs fill the QUEUE_DEPTH-sum queue and then stall the input.
// Synchronous reset clears the accumulator, the queue and the result valid flag.
module euclidean_distance_engine #(
   parameter int QUEUE_DEPTH = edist_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [edist_pkg::FEAT_W-1:0]  req_feature_a,
   input  logic [edist_pkg::FEAT_W-1:0]  req_feature_b,
   input  logic [edist_pkg::IDX_W-1:0]   req_row_index,
   input  logic [edist_pkg::IDX_W-1:0]   req_col_index,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [edist_pkg::DIST_W-1:0]  rsp_distance,
   output logic [edist_pkg::SUM_W-1:0]   rsp_sum_squares,
   output logic [edist_pkg::IDX_W-1:0]   rsp_pair_row,
   output logic [edist_pkg::IDX_W-1:0]   rsp_pair_col
);
   import edist_pkg::*;

   logic      push_valid;
   entry_type push_entry;
   logic      queue_full;
   logic      pop_ready;
   logic      pop_valid;
   entry_type pop_entry;

   // Accumulate element squares
   edist_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_feature_a    (req_feature_a),
      .req_feature_b    (req_feature_b),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_last_element (req_last_element),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   // Decouple accumulation from the root
   edist_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Take the root and present the result
   edist_sqrt u_sqrt (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance    (rsp_distance),
      .rsp_sum_squares (rsp_sum_squares),
      .rsp_pair_row    (rsp_pair_row),
      .rsp_pair_col    (rsp_pair_col)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench for euclidean_distance_engine: drives element beats,
// predicts each distance result and checks every result beat against it.
// Depends on edist_pkg and the euclidean_distance_engine RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import edist_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [SUM_W-1:0]  sum_squares;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
   } distance_result_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [FEAT_W-1:0] req_feature_a    = '0;
   logic [FEAT_W-1:0] req_feature_b    = '0;
   logic [IDX_W-1:0]  req_row_index    = '0;
   logic [IDX_W-1:0]  req_col_index    = '0;
   logic              req_last_element = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [DIST_W-1:0] rsp_distance;
   logic [SUM_W-1:0]  rsp_sum_squares;
   logic [IDX_W-1:0]  rsp_pair_row;
   logic [IDX_W-1:0]  rsp_pair_col;

   // Predicted results in order, and the running sum of the current vector pair
   distance_result_type pending_results[$];
   logic [SUM_W-1:0] running_sum = '0;

   int gap_pct        = 0;
   int stall_pct      = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   euclidean_distance_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_feature_a    (req_feature_a),
      .req_feature_b    (req_feature_b),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance     (rsp_distance),
      .rsp_sum_squares  (rsp_sum_squares),
      .rsp_pair_row     (rsp_pair_row),
      .rsp_pair_col     (rsp_pair_col)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Floor square root, one result bit at a time from the top
   function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] value);
      logic [DIST_W-1:0] root;
      root = '0;
      for (int k = DIST_W - 1; k >= 0; k--) begin
         root[k] = 1'b1;
         if (32'(root) * 32'(root) > 32'(value))
            root[k] = 1'b0;
      end
      return root;
   endfunction

   // Add one element pair to the running sum; close the vector pair on last
   function automatic void accumulate_element(input logic [FEAT_W-1:0] a, b,
                                              input logic [IDX_W-1:0] row, col,
                                              input logic last);
      logic [SUM_W:0]   diff;
      logic [SUM_W:0]   total;
      distance_result_type result;
      diff  = (SUM_W + 1)'((a >= b) ? a - b : b - a);
      total = {1'b0, running_sum} + diff * diff;
      if (total > {1'b0, SUM_LIMIT})
         total = {1'b0, SUM_LIMIT};
      if (!last) begin
         running_sum = total[SUM_W-1:0];
      end else begin
         result.sum_squares = total[SUM_W-1:0];
         result.distance    = floor_root(total[SUM_W-1:0]);
         result.row         = row;
         result.col         = col;
         pending_results.push_back(result);
         running_sum = '0;
      end
   endfunction

   function automatic logic [FEAT_W-1:0] pick_feature();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return FEAT_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one element beat after a random gap and hold it until accepted
   task automatic send_element(input logic [FEAT_W-1:0] a, b,
                               input logic [IDX_W-1:0] row, col,
                               input logic last);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_feature_a    <= a;
      req_feature_b    <= b;
      req_row_index    <= row;
      req_col_index    <= col;
      req_last_element <= last;
      do @(posedge clock); while (!req_ready);
      accumulate_element(a, b, row, col, last);
   endtask

   // Stop offering beats and wait until every predicted result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Send one vector pair; a wandering pair changes its indices on every beat
   task automatic send_vector_pair(input int length, input logic [FEAT_W-1:0] a_fixed,
                                   input logic [FEAT_W-1:0] b_fixed, input bit use_fixed,
                                   input bit wander);
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [FEAT_W-1:0] a;
      logic [FEAT_W-1:0] b;
      row = IDX_W'($urandom_range(8191));
      col = IDX_W'($urandom_range(8191));
      for (int i = 0; i < length; i++) begin
         if (wander) begin
            row = IDX_W'($urandom_range(8191));
            col = IDX_W'($urandom_range(8191));
         end
         a = use_fixed ? a_fixed : pick_feature();
         b = use_fixed ? b_fixed : pick_feature();
         send_element(a, b, row, col, i == length - 1);
      end
   endtask

   task automatic test_directed_extremes();
      gap_pct   = 0;
      stall_pct = 0;
      // Single-beat pairs at the corners of the feature and index ranges
      send_element(8'd0,   8'd0,   13'd0,     13'd0,     1'b1);
      send_element(8'd255, 8'd0,   13'd8191,  13'd8191,  1'b1);
      send_element(8'd0,   8'd255, 13'd0,     13'd8191,  1'b1);
      send_element(8'd255, 8'd255, 13'd8191,  13'd0,     1'b1);
      send_element(8'h55,  8'hAA,  13'h0AAA,  13'h1555,  1'b1);
      // Running sum just below and at a perfect square
      send_element(8'd10,  8'd7,   13'd5,     13'd6,     1'b0);
      send_element(8'd7,   8'd9,   13'd5,     13'd6,     1'b0);
      send_element(8'd0,   8'd1,   13'd5,     13'd6,     1'b0);
      send_element(8'd1,   8'd0,   13'd5,     13'd6,     1'b1);
      send_element(8'd4,   8'd0,   13'd12,    13'd34,    1'b1);
      // Two full-scale differences
      send_element(8'd0,   8'd255, 13'd77,    13'd88,    1'b0);
      send_element(8'd255, 8'd0,   13'd77,    13'd88,    1'b1);
      // Indices change mid pair: the last beat's indices win
      send_element(8'd100, 8'd200, 13'd1,     13'd2,     1'b0);
      send_element(8'd50,  8'd60,  13'h1555,  13'h0AAA,  1'b0);
      send_element(8'd0,   8'd0,   13'd8191,  13'd1234,  1'b1);
      drain_results();
   endtask

   // Full-scale differences through the element limit and beyond it
   task automatic test_saturation();
      gap_pct   = 0;
      stall_pct = 0;
      send_vector_pair(MAX_ELEMENTS + 40, 8'd0, 8'd255, 1'b1, 1'b0);
      drain_results();
   endtask

   // Well-formed vector pairs of random length under one idling setting
   task automatic test_random_pairs(input int sender_gap, input int receiver_stall,
                                    input int budget);
      int sent;
      int length;
      gap_pct   = sender_gap;
      stall_pct = receiver_stall;
      sent      = 0;
      while (sent < budget) begin
         length = ($urandom_range(24) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
         send_vector_pair(length, '0, '0, 1'b0, $urandom_range(9) == 0);
         sent += length;
      end
      drain_results();
   endtask

   // Hold the receiver off while single-beat pairs arrive at full rate
   task automatic test_backpressure();
      gap_pct   = 0;
      stall_pct = 0;
      hold_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < 40; i++)
         send_vector_pair(1, '0, '0, 1'b0, 1'b0);
      drain_results();
   endtask

   // Receiver ready: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_result
      distance_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: distance %0d sum %0d row %0d col %0d",
                        rsp_distance, rsp_sum_squares, rsp_pair_row, rsp_pair_col);
         end else begin
            want = pending_results.pop_front();
            if (rsp_distance !== want.distance || rsp_sum_squares !== want.sum_squares ||
                rsp_pair_row !== want.row || rsp_pair_col !== want.col) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected distance %0d sum %0d row %0d col %0d, %s",
                           want.distance, want.sum_squares, want.row, want.col,
                           $sformatf("got distance %0d sum %0d row %0d col %0d",
                                     rsp_distance, rsp_sum_squares,
                                     rsp_pair_row, rsp_pair_col));
            end
         end
      end
   end

   // End the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_saturation();
      test_random_pairs(0, 0, 40);
      test_random_pairs(82, 0, 40);
      test_random_pairs(0, 82, 40);
      test_random_pairs(27, 27, 40);
      test_backpressure();

      // Allow any stray result to surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
